// ===== rtl/bbe_pkg.sv =====
package bbe_pkg;

    // Field and datapath widths.
    localparam int DATA_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int FRAC_BITS = 30;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Largest degree the sequencer is built for.
    localparam int DEFAULT_MAX_DEGREE = 15;

    // Register values after reset.
    localparam logic [IDX_W-1:0]         DEGREE_RESET = 4'd5;
    localparam logic signed [DATA_W-1:0] START_RESET  = 32'sd0;
    localparam logic signed [DATA_W-1:0] END_RESET    = 32'sd65536;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEGREE      = 2'd0,
        REG_RANGE_START = 2'd1,
        REG_RANGE_END   = 2'd2
    } cfg_reg_t;

    // Rounded Q.30 product and its saturation flag.
    typedef struct packed {
        logic signed [WIDE_W-1:0] value;
        logic                     sat;
    } qmul_result_t;

endpackage

// ===== rtl/bernstein_basis_eval_unit.sv =====
// Bernstein basis evaluator. Each sample word (signed Q16.16 time) yields
// degree+1 result words, basis index j = 0..N in ascending order, each a
// signed Q2.30 value C(N,j)*x^j*(1-x)^(N-j) with x = (t-start)/(end-start),
// saturated, with a flag in tuser and tlast on j = N. A zero-length interval
// gives zero values, all flagged. The block takes one sample at a time and
// drops s_tready until the last result of that sample is in the output
// register. For each sample, a bit-serial division of a 64-bit numerator
// forms x, each term is set up, runs N passes through a shared 32x32
// multiplier (one Q.30 product per pass) and is emitted, and the binomial
// coefficient for the next term goes through the same divider. Degrees
// above MAX_DEGREE are treated as MAX_DEGREE. Configuration must be
// written only while no sample is in progress; the block itself does not
// enforce this.
module bernstein_basis_eval_unit #(
    parameter int MAX_DEGREE = bbe_pkg::DEFAULT_MAX_DEGREE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Sample input; tdata: sample_time[31:0].
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bbe_pkg::DATA_W-1:0]        s_tdata,
    // Result output; tdata: basis_index[3:0], basis_value[35:4], zero[39:36].
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,
    // tuser: saturated[0].
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbe_pkg::DATA_W-1:0]        cfg_data
);

    localparam int DW   = bbe_pkg::DATA_W;
    localparam int W    = bbe_pkg::WIDE_W;
    localparam int FRAC = bbe_pkg::FRAC_BITS;
    localparam int IW   = bbe_pkg::IDX_W;
    localparam int NW   = $clog2(MAX_DEGREE + 1);
    localparam int BW   = MAX_DEGREE + 1;

    localparam logic signed [W-1:0] Q_ONE = W'(1) << FRAC;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_XWAIT = 9'b000000100,
        S_TERM  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_MULW  = 9'b000100000,
        S_EMIT  = 9'b001000000,
        S_BWAIT = 9'b010000000,
        S_ZERO  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [IW-1:0]        degree_reg;
    logic signed [DW-1:0] start_reg;
    logic signed [DW-1:0] end_reg;

    // Per-sample working registers.
    logic [DW:0]          u_reg, u_next;
    logic [DW:0]          d_reg, d_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        j_reg, j_next;
    logic [NW-1:0]        k_reg, k_next;
    logic [BW-1:0]        binom_reg, binom_next;
    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [W-1:0]  p_reg, p_next;
    logic                 sat_reg, sat_next;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [IW-1:0]        out_index_reg, out_index_next;
    logic [DW-1:0]        out_value_reg, out_value_next;
    logic                 out_sat_reg, out_sat_next;
    logic                 out_last_reg, out_last_next;

    // Shared units.
    logic                 div_start;
    logic [W-1:0]         div_num;
    logic [DW-1:0]        div_den;
    logic                 div_done;
    logic [W-1:0]         div_quot;
    logic                 qmul_start;
    logic signed [W-1:0]  qmul_b;
    logic                 qmul_done;
    bbe_pkg::qmul_result_t qmul_result;

    logic [DW:0]          u_neg;
    logic [DW:0]          d_neg;
    logic [DW-1:0]        u_mag;
    logic [DW-1:0]        d_mag;
    logic [W-1:0]         x_num;
    logic [BW+NW-1:0]     binom_prod;
    logic [W-1:0]         b_num;
    logic signed [W-1:0]  x_val;
    logic                 p_fits;
    logic [DW-1:0]        p_clip;
    logic                 out_free;
    logic [NW-1:0]        n_clamp;

    // Configuration port, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= bbe_pkg::DEGREE_RESET;
            start_reg  <= bbe_pkg::START_RESET;
            end_reg    <= bbe_pkg::END_RESET;
        end
        else if (cfg_valid)
        begin
            case (bbe_pkg::cfg_reg_t'(cfg_index))
                bbe_pkg::REG_DEGREE:      degree_reg <= cfg_data[IW-1:0];
                bbe_pkg::REG_RANGE_START: start_reg  <= cfg_data;
                bbe_pkg::REG_RANGE_END:   end_reg    <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Magnitudes and divider operands.
    assign u_neg   = -u_reg;
    assign d_neg   = -d_reg;
    assign u_mag   = u_reg[DW] ? u_neg[DW-1:0] : u_reg[DW-1:0];
    assign d_mag   = d_reg[DW] ? d_neg[DW-1:0] : d_reg[DW-1:0];
    assign x_num   = W'({u_mag, {FRAC{1'b0}}}) + W'(d_mag >> 1);
    assign binom_prod = binom_reg * (n_reg - j_reg);
    assign b_num   = W'(binom_prod);
    assign div_num = (state_reg == S_PREP) ? x_num : b_num;
    assign div_den = (state_reg == S_PREP) ? d_mag : (DW'(j_reg) + DW'(1));
    assign x_val   = (u_reg[DW] ^ d_reg[DW]) ? -$signed(div_quot) : $signed(div_quot);

    // Powers of x come first, then powers of 1-x.
    assign qmul_b  = (k_reg < j_reg) ? x_reg : y_reg;

    // Clip the Q.30 product to the signed 32-bit result.
    assign p_fits  = (p_reg[W-1:DW-1] == {(W-DW+1){p_reg[W-1]}});
    assign p_clip  = p_fits ? p_reg[DW-1:0] :
                     (p_reg[W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

    assign out_free = !out_valid_reg || m_tready;
    assign n_clamp  = (int'(degree_reg) > MAX_DEGREE) ? NW'(MAX_DEGREE) : NW'(degree_reg);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        u_next         = u_reg;
        d_next         = d_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        binom_next     = binom_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        p_next         = p_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        out_last_next  = out_last_reg;
        div_start      = 1'b0;
        qmul_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    u_next     = {s_tdata[DW-1], s_tdata} - {start_reg[DW-1], start_reg};
                    d_next     = {end_reg[DW-1], end_reg} - {start_reg[DW-1], start_reg};
                    n_next     = n_clamp;
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                j_next = '0;
                if (d_reg == '0)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_XWAIT;
                end
            end

            S_XWAIT:
            begin
                if (div_done)
                begin
                    x_next     = x_val;
                    y_next     = Q_ONE - x_val;
                    binom_next = BW'(1);
                    state_next = S_TERM;
                end
            end

            S_TERM:
            begin
                p_next     = W'(binom_reg) << FRAC;
                sat_next   = 1'b0;
                k_next     = '0;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    qmul_start = 1'b1;
                    state_next = S_MULW;
                end
            end

            S_MULW:
            begin
                if (qmul_done)
                begin
                    p_next     = qmul_result.value;
                    sat_next   = sat_reg | qmul_result.sat;
                    k_next     = k_reg + 1'b1;
                    state_next = S_MUL;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = IW'(j_reg);
                    out_value_next = p_clip;
                    out_sat_next   = sat_reg | !p_fits;
                    out_last_next  = (j_reg == n_reg);
                    if (j_reg == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Next coefficient: C(n,j+1) = C(n,j)*(n-j)/(j+1).
                        div_start  = 1'b1;
                        state_next = S_BWAIT;
                    end
                end
            end

            S_BWAIT:
            begin
                if (div_done)
                begin
                    binom_next = div_quot[BW-1:0];
                    j_next     = j_reg + 1'b1;
                    state_next = S_TERM;
                end
            end

            S_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = IW'(j_reg);
                    out_value_next = '0;
                    out_sat_next   = 1'b1;
                    out_last_next  = (j_reg == n_reg);
                    j_next         = j_reg + 1'b1;
                    if (j_reg == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        u_reg         <= u_next;
        d_reg         <= d_next;
        n_reg         <= n_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        binom_reg     <= binom_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        p_reg         <= p_next;
        sat_reg       <= sat_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_sat_reg   <= out_sat_next;
        out_last_reg  <= out_last_next;
    end

    // Shared divider for x and for the binomial coefficients.
    bbe_div #(
        .NUM_W (W),
        .DEN_W (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Shared Q.30 multiplier.
    bbe_qmul u_qmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (qmul_start),
        .a      (p_reg),
        .b      (qmul_b),
        .done   (qmul_done),
        .result (qmul_result)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_value_reg, out_index_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/bbe_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module bbe_div #(
    parameter int NUM_W = bbe_pkg::WIDE_W,
    parameter int DEN_W = bbe_pkg::DATA_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    // Bring down the next numerator bit and try a subtraction.
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = (rem_shift >= {1'b0, den_reg});
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    // Sequencing control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== rtl/bbe_qmul.sv =====
// Signed Q.30 multiply on 64-bit operands, built from four 32x32 partial
// products on one multiplier. Rounds to nearest with ties away from zero on
// the magnitude and holds the magnitude at 2^62 on overflow.
module bbe_qmul (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [bbe_pkg::WIDE_W-1:0]      a,
    input  logic signed [bbe_pkg::WIDE_W-1:0]      b,
    output logic                                   done,
    output bbe_pkg::qmul_result_t                  result
);

    localparam int W       = bbe_pkg::WIDE_W;
    localparam int HALF    = W / 2;
    localparam int ACC_W   = 2 * W;
    localparam int FRAC    = bbe_pkg::FRAC_BITS;
    localparam int CAP_POS = W - 2;
    localparam int OVF_LSB = FRAC + CAP_POS;

    logic             busy_reg;
    logic             done_reg;
    logic [2:0]       step_reg;
    logic [W-1:0]     ua_reg;
    logic [W-1:0]     ub_reg;
    logic             neg_reg;
    logic [W-1:0]     mul_reg;
    logic [ACC_W-1:0] acc_reg;
    bbe_pkg::qmul_result_t result_reg;

    logic [W-1:0]     ua_in;
    logic [W-1:0]     ub_in;
    logic [HALF-1:0]  a_half;
    logic [HALF-1:0]  b_half;
    logic [W-1:0]     mul_next;
    logic [ACC_W-1:0] addend;
    logic [ACC_W-1:0] acc_next;
    logic             ovf;
    logic [W-1:0]     mag;
    logic signed [W-1:0] value;

    assign ua_in = a[W-1] ? W'(-a) : W'(a);
    assign ub_in = b[W-1] ? W'(-b) : W'(b);

    // Steps 0..3 form a0*b0, a0*b1, a1*b0, a1*b1.
    assign a_half   = step_reg[1] ? ua_reg[W-1:HALF] : ua_reg[HALF-1:0];
    assign b_half   = step_reg[0] ? ub_reg[W-1:HALF] : ub_reg[HALF-1:0];
    assign mul_next = a_half * b_half;

    // The registered partial product is added one step later at its weight.
    always_comb
    begin
        case (step_reg)
            3'd1:       addend = {{W{1'b0}}, mul_reg};
            3'd2, 3'd3: addend = {{HALF{1'b0}}, mul_reg, {HALF{1'b0}}};
            3'd4:       addend = {mul_reg, {W{1'b0}}};
            default:    addend = '0;
        endcase
    end

    assign acc_next = acc_reg + addend;

    // Scale down by 2^30 and hold the magnitude at 2^62.
    assign ovf   = |acc_reg[ACC_W-1:OVF_LSB];
    assign mag   = ovf ? (W'(1) << CAP_POS) : {2'b00, acc_reg[OVF_LSB-1:FRAC]};
    assign value = neg_reg ? -$signed(mag) : $signed(mag);

    // Step sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands, product and accumulator. The accumulator starts at the
    // rounding constant, half of the dropped weight.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= ua_in;
            ub_reg  <= ub_in;
            neg_reg <= a[W-1] ^ b[W-1];
            acc_reg <= ACC_W'(1) << (FRAC - 1);
        end
        else if (busy_reg)
        begin
            mul_reg <= mul_next;
            acc_reg <= acc_next;
            if (step_reg == 3'd5)
            begin
                result_reg.value <= value;
                result_reg.sat   <= ovf;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
